FILE: rtl/frq_pkg.sv
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and defaults for the ready queue: operation and status codes
// and the default queue geometry.
// ----------------------------------------------------------------------------
package frq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADMIT  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

FILE: rtl/fifo_ready_queue_with_removal_core.sv
// ----------------------------------------------------------------------------
// fifo_ready_queue_with_removal_core
// Admit, pop, remove-by-value and flush on a queue of thread handles, kept as
// a circular buffer in one synchronous single-read, single-write memory.
// ----------------------------------------------------------------------------
// Admit, flush and a pop or remove on an empty queue answer from idle, with the result
// strobe in the cycle after start; other pops pass through the pop state. A remove
// scans from the head up to the match (or the end) and on a match moves the entries
// behind it one place toward the head; the memory read port paces this, one entry read
// per cycle. Busy is high while an operation is in flight; the next word is taken as
// early as the cycle its result strobe is high. Reset empties the queue, not the memory.
module fifo_ready_queue_with_removal_core #(
    parameter int QUEUE_DEPTH  = frq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = frq_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [frq_pkg::OP_W-1:0]            i_op,
    input  logic [HANDLE_WIDTH-1:0]             i_thread_handle,
    output logic                                o_valid,
    output logic [HANDLE_WIDTH-1:0]             o_popped_handle,
    output logic [frq_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_queue_length
);
    import frq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } t_state;

    // Physical slot of the entry at a given distance from the head.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [HANDLE_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [HANDLE_WIDTH-1:0] r_rd_data;

    t_state                  r_state;
    logic [AW-1:0]           r_head;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [HANDLE_WIDTH-1:0] r_handle;

    logic                    r_valid;
    logic [HANDLE_WIDTH-1:0] r_popped;
    t_status                 r_status;
    logic [CW-1:0]           r_len;

    logic                    accept;
    t_op                     op_in;
    logic                    full;
    logic [CW:0]             idx_next;
    logic [CW:0]             rd_off;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [HANDLE_WIDTH-1:0] wr_data;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign op_in    = t_op'(i_op);
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign idx_next = (CW+1)'(r_idx) + (CW+1)'(1);

    // The read runs one entry ahead of the entry being examined.
    always_comb begin
        case (r_state)
            S_SCAN:  rd_off = idx_next;
            S_SHIFT: rd_off = idx_next + (CW+1)'(1);
            default: rd_off = '0;
        endcase
        if (rd_off >= (CW+1)'(r_count)) begin
            rd_off = '0;
        end
        rd_addr = slot(r_head, rd_off[CW-1:0]);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot(r_head, r_idx);
        wr_data = r_rd_data;
        if (r_state == S_IDLE) begin
            wr_en   = accept && (op_in == OP_ADMIT) && !full;
            wr_addr = slot(r_head, r_count);
            wr_data = i_thread_handle;
        end else if (r_state == S_SHIFT) begin
            wr_en = (idx_next < (CW+1)'(r_count));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_handle <= i_thread_handle;
                        r_idx    <= '0;
                        r_popped <= '0;
                        case (op_in)
                            OP_ADMIT: begin
                                r_valid <= 1'b1;
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_len    <= r_count;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_count  <= r_count + CW'(1);
                                    r_len    <= r_count + CW'(1);
                                end
                            end
                            OP_REMOVE, OP_POP: begin
                                if (r_count == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_EMPTY;
                                    r_len    <= r_count;
                                end else begin
                                    r_state <= (op_in == OP_POP) ? S_POP : S_SCAN;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_DONE;
                                r_head   <= '0;
                                r_count  <= '0;
                                r_len    <= '0;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_valid  <= 1'b1;
                    r_popped <= r_rd_data;
                    r_status <= ST_DONE;
                    r_head   <= slot(r_head, CW'(1));
                    r_count  <= r_count - CW'(1);
                    r_len    <= r_count - CW'(1);
                    r_state  <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_rd_data == r_handle) begin
                        r_state <= S_SHIFT;
                    end else if (idx_next >= (CW+1)'(r_count)) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_EMPTY;
                        r_len    <= r_count;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= idx_next[CW-1:0];
                    end
                end
                S_SHIFT: begin
                    // Entries behind the match move one place toward the head.
                    if (idx_next < (CW+1)'(r_count)) begin
                        r_idx <= idx_next[CW-1:0];
                    end else begin
                        r_valid  <= 1'b1;
                        r_status <= ST_DONE;
                        r_count  <= r_count - CW'(1);
                        r_len    <= r_count - CW'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_popped_handle = r_popped;
    assign o_status        = r_status;
    assign o_queue_length  = r_len;

endmodule
